FILE: design/cprd_pkg.sv
package cprd_pkg;

	// fixed screen geometry
	localparam int SCREEN_WIDTH  = 900;
	localparam int SCREEN_HEIGHT = 800;

	// port widths
	localparam int PIX_W      = 10;
	localparam int COMP_W     = 16;
	localparam int VEC_W      = 3 * COMP_W;
	localparam int VIEW_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = VEC_W;
	localparam int IN_DATA_W  = ((2 * PIX_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = VEC_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FORWARD     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UP          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIDE        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 3'd4;

	// register reset values
	localparam logic [VEC_W-1:0]  RESET_FORWARD = 48'h4000_0000_0000;
	localparam logic [VEC_W-1:0]  RESET_UP      = 48'h0000_4000_0000;
	localparam logic [VEC_W-1:0]  RESET_SIDE    = 48'h0000_0000_4000;
	localparam logic [VIEW_W-1:0] RESET_VIEW    = 16'h0100;

	localparam int FRAC = 14;

	// pixel map: |2p - size| * 2^14 + size/2, divided by size via reciprocal
	localparam int D_W   = 13;
	localparam int MAP_N = 27;
	localparam int M_W   = MAP_N + 2;
	localparam int MAP_SHIFT_X = MAP_N + $clog2(SCREEN_WIDTH);
	localparam int MAP_SHIFT_Y = MAP_N + $clog2(SCREEN_HEIGHT);
	localparam longint MAP_RECIP_X =
		((longint'(1) << MAP_SHIFT_X) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
	localparam longint MAP_RECIP_Y =
		((longint'(1) << MAP_SHIFT_Y) + SCREEN_HEIGHT - 1) / SCREEN_HEIGHT;

	localparam int PIX_MAX = (1 << PIX_W) - 1;
	localparam int MAXD_X = (SCREEN_WIDTH > 2 * PIX_MAX - SCREEN_WIDTH) ?
		SCREEN_WIDTH : 2 * PIX_MAX - SCREEN_WIDTH;
	localparam int MAXD_Y = (SCREEN_HEIGHT > 2 * PIX_MAX - SCREEN_HEIGHT) ?
		SCREEN_HEIGHT : 2 * PIX_MAX - SCREEN_HEIGHT;
	localparam longint MAP_MAX_X =
		(longint'(MAXD_X) * 16384 + SCREEN_WIDTH / 2) / SCREEN_WIDTH;
	localparam longint MAP_MAX_Y =
		(longint'(MAXD_Y) * 16384 + SCREEN_HEIGHT / 2) / SCREEN_HEIGHT;
	localparam longint MAP_MAX = (MAP_MAX_X > MAP_MAX_Y) ? MAP_MAX_X : MAP_MAX_Y;
	localparam int MAP_W = $clog2(MAP_MAX + 1) + 1;

	// scaled map, basis products, rounded terms, vector sum
	localparam int PW_W   = MAP_W + VIEW_W + 1;
	localparam int SC_W   = MAP_W + 9;
	localparam int P_W    = SC_W + COMP_W;
	localparam int TERM_W = P_W - 13;
	localparam int SUM_W  = (TERM_W + 2 > 33) ? TERM_W + 2 : 33;

	// normalization
	localparam int V_W    = 31;
	localparam int L_W    = 2 * V_W;
	localparam int ROOT_W = V_W;
	localparam int RTR_W  = ROOT_W + 2;
	localparam int QUO_W  = 15;
	localparam int DIVD_W = V_W + FRAC + 1;
	localparam longint SUM_LIMIT = longint'(1) << 30;

endpackage

FILE: design/camera_primary_ray_direction_unit.sv
// Primary ray direction of a pinhole camera. Each beat on s_ carries one pixel
// coordinate pair; each beat on m_ carries the unit direction of the ray through
// that pixel in signed Q1.14, with the degenerate flag in m_tuser when the summed
// vector had zero length (direction then zero). Throughput is one pixel per clock
// while the skid is empty. An accepted input beat passes through nine stages of
// map, scale, basis sum and squared length, then a square root that resolves one
// result bit per stage (31 stages), a division setup stage, a restoring divider
// that resolves one quotient bit per stage (15 stages, one lane per component),
// and a final sign and clamp stage. Result order equals input order. A two-entry
// output (output register plus skid) lets the block take one more pixel while a
// result waits; the whole pipeline holds only once the skid is full. Camera
// vectors and view sizes come from the write port and should be changed only
// while no pixel is in flight.
module camera_primary_ray_direction_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// pixel_x [9:0], pixel_y [19:10], zero above
	input  logic [cprd_pkg::IN_DATA_W-1:0]       s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// dir_x [15:0], dir_y [31:16], dir_z [47:32]
	output logic [cprd_pkg::OUT_DATA_W-1:0]      m_tdata,
	// degenerate [0]
	output logic                                 m_tuser,
	input  logic                                 cfg_we,
	input  logic [cprd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cprd_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import cprd_pkg::*;

	// configuration registers
	logic [VEC_W-1:0]  forward_q, up_q, side_q;
	logic [VIEW_W-1:0] view_height_q, view_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forward_q     <= RESET_FORWARD;
			up_q          <= RESET_UP;
			side_q        <= RESET_SIDE;
			view_height_q <= RESET_VIEW;
			view_width_q  <= RESET_VIEW;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FORWARD:     forward_q     <= cfg_data;
				REG_UP:          up_q          <= cfg_data;
				REG_SIDE:        side_q        <= cfg_data;
				REG_VIEW_HEIGHT: view_height_q <= cfg_data[VIEW_W-1:0];
				REG_VIEW_WIDTH:  view_width_q  <= cfg_data[VIEW_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline advances whenever the skid stage is empty
	logic en;
	logic skid_valid_q;
	assign en       = !skid_valid_q;
	assign s_tready = en;

	// ---------------------------------------------------------------------
	// s1: pixel offset from screen center, rounded divide by reciprocal
	// ---------------------------------------------------------------------
	logic signed [D_W-1:0] dx, dy;
	logic [D_W-1:0]        dx_abs, dy_abs;
	logic [MAP_N-1:0]      ax, ay;

	always_comb begin
		dx = $signed({2'b00, s_tdata[PIX_W-1:0], 1'b0}) - D_W'(SCREEN_WIDTH);
		dy = $signed({2'b00, s_tdata[2*PIX_W-1:PIX_W], 1'b0}) - D_W'(SCREEN_HEIGHT);
		dx_abs = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
		dy_abs = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
		ax = MAP_N'({dx_abs, {FRAC{1'b0}}}) + MAP_N'(SCREEN_WIDTH / 2);
		ay = MAP_N'({dy_abs, {FRAC{1'b0}}}) + MAP_N'(SCREEN_HEIGHT / 2);
	end

	logic                   valid_s1;
	logic [MAP_N+M_W-1:0]   px_s1, py_s1;
	logic                   nx_s1, ny_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= (MAP_N+M_W)'(ax) * (MAP_N+M_W)'(M_W'(MAP_RECIP_X));
			py_s1 <= (MAP_N+M_W)'(ay) * (MAP_N+M_W)'(M_W'(MAP_RECIP_Y));
			nx_s1 <= dx[D_W-1];
			ny_s1 <= dy[D_W-1];
		end
	end

	// ---------------------------------------------------------------------
	// s2: signed map values in Q.14
	// ---------------------------------------------------------------------
	logic                     valid_s2;
	logic signed [MAP_W-1:0]  mx_s2, my_s2;
	logic [MAP_W-1:0]         mx_mag, my_mag;

	always_comb begin
		mx_mag = {1'b0, px_s1[MAP_SHIFT_X +: MAP_W-1]};
		my_mag = {1'b0, py_s1[MAP_SHIFT_Y +: MAP_W-1]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2 <= nx_s1 ? $signed(-mx_mag) : $signed(mx_mag);
			my_s2 <= ny_s1 ? $signed(-my_mag) : $signed(my_mag);
		end
	end

	// ---------------------------------------------------------------------
	// s3: times view size
	// ---------------------------------------------------------------------
	logic                    valid_s3;
	logic signed [PW_W-1:0]  pwx_s3, pwy_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			pwx_s3 <= $signed({1'b0, view_width_q}) * mx_s2;
			pwy_s3 <= $signed({1'b0, view_height_q}) * my_s2;
		end
	end

	// ---------------------------------------------------------------------
	// s4: round off eight fraction bits of the view size
	// ---------------------------------------------------------------------
	logic                    valid_s4;
	logic signed [SC_W-1:0]  sx_s4, sy_s4;
	logic [PW_W-1:0]         pwx_abs, pwy_abs;
	logic [SC_W-1:0]         sx_mag, sy_mag;

	always_comb begin
		pwx_abs = pwx_s3[PW_W-1] ? PW_W'(-pwx_s3) : PW_W'(pwx_s3);
		pwy_abs = pwy_s3[PW_W-1] ? PW_W'(-pwy_s3) : PW_W'(pwy_s3);
		sx_mag  = SC_W'((pwx_abs + PW_W'(128)) >> 8);
		sy_mag  = SC_W'((pwy_abs + PW_W'(128)) >> 8);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s4 <= pwx_s3[PW_W-1] ? $signed(-sx_mag) : $signed(sx_mag);
			sy_s4 <= pwy_s3[PW_W-1] ? $signed(-sy_mag) : $signed(sy_mag);
		end
	end

	// ---------------------------------------------------------------------
	// s5: up and side components times the scaled maps
	// ---------------------------------------------------------------------
	logic                   valid_s5;
	logic signed [P_W-1:0]  up_p_s5 [3];
	logic signed [P_W-1:0]  sd_p_s5 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				up_p_s5[k] <= $signed(up_q[COMP_W*k +: COMP_W]) * sy_s4;
				sd_p_s5[k] <= $signed(side_q[COMP_W*k +: COMP_W]) * sx_s4;
			end
		end
	end

	// ---------------------------------------------------------------------
	// s6: round products back to signed Q13.14
	// ---------------------------------------------------------------------
	logic                      valid_s6;
	logic signed [TERM_W-1:0]  up_t_s6 [3];
	logic signed [TERM_W-1:0]  sd_t_s6 [3];
	logic [P_W-1:0]            up_abs [3];
	logic [P_W-1:0]            sd_abs [3];
	logic [TERM_W-1:0]         up_mag [3];
	logic [TERM_W-1:0]         sd_mag [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			up_abs[k] = up_p_s5[k][P_W-1] ? P_W'(-up_p_s5[k]) : P_W'(up_p_s5[k]);
			sd_abs[k] = sd_p_s5[k][P_W-1] ? P_W'(-sd_p_s5[k]) : P_W'(sd_p_s5[k]);
			up_mag[k] = TERM_W'((up_abs[k] + P_W'(8192)) >> FRAC);
			sd_mag[k] = TERM_W'((sd_abs[k] + P_W'(8192)) >> FRAC);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				up_t_s6[k] <= up_p_s5[k][P_W-1] ? $signed(-up_mag[k]) : $signed(up_mag[k]);
				sd_t_s6[k] <= sd_p_s5[k][P_W-1] ? $signed(-sd_mag[k]) : $signed(sd_mag[k]);
			end
		end
	end

	// ---------------------------------------------------------------------
	// s7: sum with forward, saturate to +-2^30, split sign and magnitude
	// ---------------------------------------------------------------------
	logic                    valid_s7;
	logic [V_W-1:0]          mag_s7 [3];
	logic [2:0]              neg_s7;
	logic signed [SUM_W-1:0] vsum [3];
	logic [SUM_W-1:0]        vabs [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			vsum[k] = SUM_W'($signed(forward_q[COMP_W*k +: COMP_W]))
				+ SUM_W'(up_t_s6[k]) + SUM_W'(sd_t_s6[k]);
			vabs[k] = vsum[k][SUM_W-1] ? SUM_W'(-vsum[k]) : SUM_W'(vsum[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				neg_s7[k] <= vsum[k][SUM_W-1];
				mag_s7[k] <= (vabs[k] > SUM_W'(SUM_LIMIT)) ?
					V_W'(SUM_LIMIT) : V_W'(vabs[k]);
			end
		end
	end

	// ---------------------------------------------------------------------
	// s8: squares
	// ---------------------------------------------------------------------
	logic            valid_s8;
	logic [L_W-1:0]  sq_s8 [3];
	logic [V_W-1:0]  mag_s8 [3];
	logic [2:0]      neg_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s8[k]  <= L_W'(mag_s7[k]) * L_W'(mag_s7[k]);
				mag_s8[k] <= mag_s7[k];
			end
			neg_s8 <= neg_s7;
		end
	end

	// ---------------------------------------------------------------------
	// s9: squared length and zero check
	// ---------------------------------------------------------------------
	logic            valid_s9;
	logic [L_W-1:0]  len2_s9;
	logic [V_W-1:0]  mag_s9 [3];
	logic [2:0]      neg_s9;
	logic            deg_s9;
	logic [L_W-1:0]  len2;

	assign len2 = sq_s8[0] + sq_s8[1] + sq_s8[2];

	always_ff @(posedge clk) begin
		if (en) begin
			len2_s9 <= len2;
			deg_s9  <= (len2 == '0);
			mag_s9  <= mag_s8;
			neg_s9  <= neg_s8;
		end
	end

	// ---------------------------------------------------------------------
	// square root, one result bit per stage; index is the step
	// ---------------------------------------------------------------------
	logic             rt_valid_s [ROOT_W];
	logic [L_W-1:0]   rt_len2_s  [ROOT_W];
	logic [ROOT_W-1:0] rt_root_s [ROOT_W];
	logic [RTR_W-1:0] rt_rem_s   [ROOT_W];
	logic [V_W-1:0]   rt_mag_s   [ROOT_W][3];
	logic [2:0]       rt_neg_s   [ROOT_W];
	logic             rt_deg_s   [ROOT_W];

	for (genvar j = 0; j < ROOT_W; j++) begin : g_rt
		logic [L_W-1:0]    len2_in;
		logic [ROOT_W-1:0] root_in;
		logic [RTR_W-1:0]  rem_in;
		logic [V_W-1:0]    mag_in [3];
		logic [2:0]        neg_in;
		logic              deg_in;
		logic [RTR_W+1:0]  cat;
		logic [RTR_W+1:0]  trial;
		logic              ge;

		if (j == 0) begin : g_first
			assign len2_in = len2_s9;
			assign root_in = '0;
			assign rem_in  = '0;
			assign mag_in  = mag_s9;
			assign neg_in  = neg_s9;
			assign deg_in  = deg_s9;
		end else begin : g_next
			assign len2_in = rt_len2_s[j-1];
			assign root_in = rt_root_s[j-1];
			assign rem_in  = rt_rem_s[j-1];
			assign mag_in  = rt_mag_s[j-1];
			assign neg_in  = rt_neg_s[j-1];
			assign deg_in  = rt_deg_s[j-1];
		end

		always_comb begin
			cat   = {rem_in, len2_in[2*(ROOT_W-1-j) +: 2]};
			trial = (RTR_W+2)'({root_in, 2'b01});
			ge    = (cat >= trial);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_len2_s[j] <= len2_in;
				rt_root_s[j] <= {root_in[ROOT_W-2:0], ge};
				rt_rem_s[j]  <= ge ? RTR_W'(cat - trial) : RTR_W'(cat);
				rt_mag_s[j]  <= mag_in;
				rt_neg_s[j]  <= neg_in;
				rt_deg_s[j]  <= deg_in;
			end
		end
	end

	// ---------------------------------------------------------------------
	// divider setup: dividend |v| * 2^14 + r/2, top bits preload the remainder
	// ---------------------------------------------------------------------
	logic              valid_s41;
	logic [ROOT_W-1:0] root_s41;
	logic [ROOT_W-1:0] drem_s41 [3];
	logic [QUO_W-1:0]  dlow_s41 [3];
	logic [2:0]        neg_s41;
	logic              deg_s41;
	logic [DIVD_W-1:0] divd [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			divd[k] = DIVD_W'({rt_mag_s[ROOT_W-1][k], {FRAC{1'b0}}})
				+ DIVD_W'(rt_root_s[ROOT_W-1] >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_s41 <= rt_root_s[ROOT_W-1];
			for (int k = 0; k < 3; k++) begin
				drem_s41[k] <= ROOT_W'(divd[k] >> QUO_W);
				dlow_s41[k] <= divd[k][QUO_W-1:0];
			end
			neg_s41 <= rt_neg_s[ROOT_W-1];
			deg_s41 <= rt_deg_s[ROOT_W-1];
		end
	end

	// ---------------------------------------------------------------------
	// restoring divide by the root, one quotient bit per stage, three lanes
	// ---------------------------------------------------------------------
	logic              dv_valid_s [QUO_W];
	logic [ROOT_W-1:0] dv_root_s  [QUO_W];
	logic [ROOT_W-1:0] dv_rem_s   [QUO_W][3];
	logic [QUO_W-1:0]  dv_low_s   [QUO_W][3];
	logic [QUO_W-1:0]  dv_quo_s   [QUO_W][3];
	logic [2:0]        dv_neg_s   [QUO_W];
	logic              dv_deg_s   [QUO_W];

	for (genvar j = 0; j < QUO_W; j++) begin : g_dv
		logic [ROOT_W-1:0] root_in;
		logic [ROOT_W-1:0] rem_in [3];
		logic [QUO_W-1:0]  low_in [3];
		logic [QUO_W-1:0]  quo_in [3];
		logic [2:0]        neg_in;
		logic              deg_in;
		logic [ROOT_W:0]   cat [3];
		logic [2:0]        ge;

		if (j == 0) begin : g_first
			assign root_in = root_s41;
			assign rem_in  = drem_s41;
			assign low_in  = dlow_s41;
			assign quo_in  = '{default: '0};
			assign neg_in  = neg_s41;
			assign deg_in  = deg_s41;
		end else begin : g_next
			assign root_in = dv_root_s[j-1];
			assign rem_in  = dv_rem_s[j-1];
			assign low_in  = dv_low_s[j-1];
			assign quo_in  = dv_quo_s[j-1];
			assign neg_in  = dv_neg_s[j-1];
			assign deg_in  = dv_deg_s[j-1];
		end

		always_comb begin
			for (int k = 0; k < 3; k++) begin
				cat[k] = {rem_in[k], low_in[k][QUO_W-1-j]};
				ge[k]  = (cat[k] >= {1'b0, root_in});
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_root_s[j] <= root_in;
				for (int k = 0; k < 3; k++) begin
					dv_rem_s[j][k] <= ge[k] ? ROOT_W'(cat[k] - {1'b0, root_in})
						: ROOT_W'(cat[k]);
					dv_quo_s[j][k] <= {quo_in[k][QUO_W-2:0], ge[k]};
				end
				dv_low_s[j] <= low_in;
				dv_neg_s[j] <= neg_in;
				dv_deg_s[j] <= deg_in;
			end
		end
	end

	// ---------------------------------------------------------------------
	// s57: sign, clamp to +-1.0, zero on degenerate
	// ---------------------------------------------------------------------
	logic                     valid_s57;
	logic [COMP_W-1:0]        dir_s57 [3];
	logic                     deg_s57;
	logic [COMP_W-1:0]        qmag [3];
	logic [COMP_W-1:0]        dfin [3];
	localparam logic [COMP_W-1:0] UNIT = COMP_W'(1 << FRAC);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qmag[k] = COMP_W'(dv_quo_s[QUO_W-1][k]);
			if (qmag[k] > UNIT) qmag[k] = UNIT;
			dfin[k] = dv_neg_s[QUO_W-1][k] ? COMP_W'(-qmag[k]) : qmag[k];
			if (dv_deg_s[QUO_W-1]) dfin[k] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dir_s57 <= dfin;
			deg_s57 <= dv_deg_s[QUO_W-1];
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			rt_valid_s <= '{default: 1'b0};
			valid_s41 <= 1'b0;
			dv_valid_s <= '{default: 1'b0};
			valid_s57 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
			rt_valid_s[0] <= valid_s9;
			for (int j = 1; j < ROOT_W; j++) rt_valid_s[j] <= rt_valid_s[j-1];
			valid_s41 <= rt_valid_s[ROOT_W-1];
			dv_valid_s[0] <= valid_s41;
			for (int j = 1; j < QUO_W; j++) dv_valid_s[j] <= dv_valid_s[j-1];
			valid_s57 <= dv_valid_s[QUO_W-1];
		end
	end

	// ---------------------------------------------------------------------
	// output register and skid
	// ---------------------------------------------------------------------
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q, skid_data_q;
	logic                  out_deg_q, skid_deg_q;
	logic                  take, out_free, tail_go;
	logic [OUT_DATA_W-1:0] tail_data;

	assign take      = out_valid_q && m_tready;
	assign out_free  = !out_valid_q || take;
	assign tail_go   = en && valid_s57;
	assign tail_data = {dir_s57[2], dir_s57[1], dir_s57[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_free) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (tail_go) begin
			if (out_free) out_valid_q <= 1'b1;
			else skid_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_free) begin
				out_data_q <= skid_data_q;
				out_deg_q  <= skid_deg_q;
			end
		end else if (tail_go) begin
			if (out_free) begin
				out_data_q <= tail_data;
				out_deg_q  <= deg_s57;
			end else begin
				skid_data_q <= tail_data;
				skid_deg_q  <= deg_s57;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_deg_q;

	// ---------------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------------
	// the skid only fills behind a waiting result
	assert property (@(posedge clk) disable iff (!arst_n) skid_valid_q |-> out_valid_q)
		else $error("skid holds a beat while the output register is empty");

	// a degenerate result carries a zero direction
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("degenerate result with nonzero direction");

	// the valid bit of the squares stage reaches the squared length stage whenever the pipeline is enabled
	assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s8) |=> valid_s9)
		else $error("valid bit lost between squares and length stage");

	// the skid never fills on its own while the output is free
	assert property (@(posedge clk) disable iff (!arst_n)
		(!skid_valid_q && out_free) |=> !skid_valid_q)
		else $error("skid filled although the output register was free");

endmodule
